@@ rtl/nfcs_pkg.sv @@
// Package for the NOR flash command sequencer: field widths, codes, flash command
// constants, shared structs and the result-sequence functions.
// No dependencies.
package nfcs_pkg;

	localparam int ADDR_W = 20;
	localparam int DATA_W = 16;

	// item kinds on the input side
	localparam logic [1:0] FN_PROG  = 2'd0;
	localparam logic [1:0] FN_ERASE = 2'd1;
	localparam logic [1:0] FN_IDENT = 2'd2;
	localparam logic [1:0] FN_RESP  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_WR   = 2'd0;
	localparam logic [1:0] KIND_RD   = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// done status
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FAIL   = 2'd1;
	localparam logic [1:0] ST_PROT   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	// flash command set
	localparam logic [ADDR_W-1:0] UNLOCK1_ADDR = ADDR_W'(12'h555);
	localparam logic [ADDR_W-1:0] UNLOCK2_ADDR = ADDR_W'(12'h2aa);
	localparam logic [DATA_W-1:0] UNLOCK1_DATA = DATA_W'(8'haa);
	localparam logic [DATA_W-1:0] UNLOCK2_DATA = DATA_W'(8'h55);
	localparam logic [DATA_W-1:0] CMD_PROG     = DATA_W'(8'ha0);
	localparam logic [DATA_W-1:0] CMD_ERASE    = DATA_W'(8'h80);
	localparam logic [DATA_W-1:0] CMD_SECTOR   = DATA_W'(8'h30);
	localparam logic [DATA_W-1:0] CMD_RESET    = DATA_W'(8'hf0);
	localparam logic [DATA_W-1:0] CMD_AUTOSEL  = DATA_W'(8'h90);
	localparam logic [DATA_W-1:0] MFR_ID_A     = DATA_W'(8'h01);
	localparam logic [DATA_W-1:0] MFR_ID_B     = DATA_W'(8'h04);
	localparam logic [DATA_W-1:0] DEV_ID_A     = 16'h2249;
	localparam logic [DATA_W-1:0] DEV_ID_B     = 16'h22c4;
	localparam logic [ADDR_W-1:0] MFR_ID_ADDR  = '0;
	localparam logic [ADDR_W-1:0] DEV_ID_ADDR  = ADDR_W'(1);
	localparam int               DQ7          = 7;
	localparam int               DQ5          = 5;

	localparam logic [19:0] WIN_START_RST = 20'ha0000;
	localparam logic [19:0] WIN_END_RST   = 20'hfffff;

	localparam logic CFG_WIN_START = 1'b0;
	localparam logic CFG_WIN_END   = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_PCMP  = 4'd1,
		PH_PPOLL = 4'd2,
		PH_PFIN  = 4'd3,
		PH_MFR   = 4'd4,
		PH_DEV   = 4'd5,
		PH_EPOLL = 4'd6,
		PH_EFIN  = 4'd7
	} phase_t;

	// result sequences the emitter can play out
	typedef enum logic [2:0] {
		SQ_NONE    = 3'd0,
		SQ_DONE    = 3'd1,
		SQ_RD      = 3'd2,
		SQ_ID      = 3'd3,
		SQ_PROG    = 3'd4,
		SQ_RSTDONE = 3'd5,
		SQ_ERASE   = 3'd6
	} seq_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
		logic [DATA_W-1:0] rdata;
	} item_t;

	typedef struct packed {
		seq_t              seq;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic [1:0]        st;
	} desc_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] bus_addr;
		logic [DATA_W-1:0] bus_data;
		logic [1:0]        status;
	} result_t;

	function automatic logic [2:0] seq_last(seq_t seq);
		logic [2:0] n;
		n = 3'd0;
		case (seq)
			SQ_ID:      n = 3'd3;
			SQ_PROG:    n = 3'd4;
			SQ_RSTDONE: n = 3'd1;
			SQ_ERASE:   n = 3'd7;
			default:    n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic result_t mk(logic [1:0] kind, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d, logic [1:0] st);
		result_t r;
		r.kind     = kind;
		r.bus_addr = a;
		r.bus_data = d;
		r.status   = st;
		return r;
	endfunction

	function automatic result_t res_at(desc_t ds, logic [2:0] k);
		result_t r;
		r = mk(KIND_DONE, '0, '0, ds.st);
		case (ds.seq)
			SQ_RD: r = mk(KIND_RD, ds.addr, '0, ST_OK);
			SQ_ID, SQ_PROG: begin
				case (k)
					3'd0: r = mk(KIND_WR, UNLOCK1_ADDR, UNLOCK1_DATA, ST_OK);
					3'd1: r = mk(KIND_WR, UNLOCK2_ADDR, UNLOCK2_DATA, ST_OK);
					3'd2: r = mk(KIND_WR, UNLOCK1_ADDR,
						(ds.seq == SQ_ID) ? CMD_AUTOSEL : CMD_PROG, ST_OK);
					3'd3: r = (ds.seq == SQ_ID) ? mk(KIND_RD, ds.addr, '0, ST_OK)
						: mk(KIND_WR, ds.addr, ds.data, ST_OK);
					default: r = mk(KIND_RD, ds.addr, '0, ST_OK);
				endcase
			end
			SQ_RSTDONE: begin
				if (k == 3'd0) begin
					r = mk(KIND_WR, '0, CMD_RESET, ST_OK);
				end
			end
			SQ_ERASE: begin
				case (k)
					3'd0: r = mk(KIND_WR, '0, CMD_RESET, ST_OK);
					3'd1: r = mk(KIND_WR, UNLOCK1_ADDR, UNLOCK1_DATA, ST_OK);
					3'd2: r = mk(KIND_WR, UNLOCK2_ADDR, UNLOCK2_DATA, ST_OK);
					3'd3: r = mk(KIND_WR, UNLOCK1_ADDR, CMD_ERASE, ST_OK);
					3'd4: r = mk(KIND_WR, UNLOCK1_ADDR, UNLOCK1_DATA, ST_OK);
					3'd5: r = mk(KIND_WR, UNLOCK2_ADDR, UNLOCK2_DATA, ST_OK);
					3'd6: r = mk(KIND_WR, ds.addr, CMD_SECTOR, ST_OK);
					default: r = mk(KIND_RD, ds.addr, '0, ST_OK);
				endcase
			end
			default: r = mk(KIND_DONE, '0, '0, ds.st);
		endcase
		return r;
	endfunction

endpackage

@@ rtl/nfcs_ctrl.sv @@
// Command state of the sequencer: phase, held command, write window registers and
// the per-item decision that picks the next result sequence. Uses nfcs_pkg.
module nfcs_ctrl import nfcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [19:0]       cfg_wdata,
	input  logic              item_valid,
	input  item_t             item,
	input  logic              can_load,
	output logic              fire,
	output logic              load,
	output desc_t             desc
);

	phase_t            phase_q, phase_nx;
	logic [1:0]        cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;
	logic [ADDR_W-1:0] win_start_q, win_end_q;
	logic              hold;
	logic              dq7match, id_mfr_ok, id_dev_ok, win_new, win_held;

	assign dq7match  = item.rdata[DQ7] == data_q[DQ7];
	assign id_mfr_ok = (item.rdata == MFR_ID_A) || (item.rdata == MFR_ID_B);
	assign id_dev_ok = (item.rdata == DEV_ID_A) || (item.rdata == DEV_ID_B);
	assign win_new   = (item.addr >= win_start_q) && (item.addr <= win_end_q);
	assign win_held  = (addr_q >= win_start_q) && (addr_q <= win_end_q);

	always_comb begin
		phase_nx  = phase_q;
		hold      = 1'b0;
		desc.seq  = SQ_NONE;
		desc.addr = addr_q;
		desc.data = data_q;
		desc.st   = ST_OK;
		if (item.func != FN_RESP) begin
			if (phase_q == PH_IDLE) begin
				hold      = 1'b1;
				desc.addr = item.addr;
				desc.data = item.wdata;
				if (item.func == FN_PROG) begin
					if (!win_new) begin
						desc.seq = SQ_DONE;
						desc.st  = ST_PROT;
					end else begin
						desc.seq = SQ_RD;
						phase_nx = PH_PCMP;
					end
				end else begin
					desc.seq  = SQ_ID;
					desc.addr = MFR_ID_ADDR;
					phase_nx  = PH_MFR;
				end
			end
		end else begin
			unique case (phase_q)
				PH_PCMP: begin
					if (item.rdata == data_q) begin
						desc.seq = SQ_DONE;
						phase_nx = PH_IDLE;
					end else begin
						desc.seq = SQ_PROG;
						phase_nx = PH_PPOLL;
					end
				end
				PH_PPOLL: begin
					if (dq7match) begin
						desc.seq = SQ_DONE;
						phase_nx = PH_IDLE;
					end else begin
						desc.seq = SQ_RD;
						if (item.rdata[DQ5]) phase_nx = PH_PFIN;
					end
				end
				PH_PFIN: begin
					desc.seq = SQ_DONE;
					desc.st  = dq7match ? ST_OK : ST_FAIL;
					phase_nx = PH_IDLE;
				end
				PH_MFR: begin
					if (id_mfr_ok) begin
						desc.seq  = SQ_ID;
						desc.addr = DEV_ID_ADDR;
						phase_nx  = PH_DEV;
					end else begin
						desc.seq = SQ_RSTDONE;
						desc.st  = ST_ABSENT;
						phase_nx = PH_IDLE;
					end
				end
				PH_DEV: begin
					desc.seq = SQ_RSTDONE;
					phase_nx = PH_IDLE;
					if (!id_dev_ok) begin
						desc.st = ST_ABSENT;
					end else if (cmd_q != FN_ERASE) begin
						desc.st = ST_OK;
					end else if (!win_held) begin
						desc.st = ST_PROT;
					end else begin
						desc.seq = SQ_ERASE;
						phase_nx = PH_EPOLL;
					end
				end
				PH_EPOLL: begin
					if (item.rdata[DQ7]) begin
						desc.seq = SQ_DONE;
						phase_nx = PH_IDLE;
					end else begin
						desc.seq = SQ_RD;
						if (item.rdata[DQ5]) phase_nx = PH_EFIN;
					end
				end
				PH_EFIN: begin
					desc.seq = SQ_DONE;
					desc.st  = item.rdata[DQ7] ? ST_OK : ST_FAIL;
					phase_nx = PH_IDLE;
				end
				default: desc.seq = SQ_NONE;
			endcase
		end
	end

	// items with no results never wait for the emitter
	assign fire = item_valid && (can_load || (desc.seq == SQ_NONE));
	assign load = fire && (desc.seq != SQ_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= '0;
			addr_q  <= '0;
			data_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_nx;
			if (hold) begin
				cmd_q  <= item.func;
				addr_q <= item.addr;
				data_q <= item.wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= ADDR_W'(WIN_START_RST);
			win_end_q   <= ADDR_W'(WIN_END_RST);
		end else if (cfg_we) begin
			if (cfg_index == CFG_WIN_START) win_start_q <= ADDR_W'(cfg_wdata);
			else                            win_end_q   <= ADDR_W'(cfg_wdata);
		end
	end

endmodule

@@ rtl/nfcs_emit.sv @@
// Result stage: holds one result sequence and plays it out one bus access per
// transaction on the output side. Uses nfcs_pkg.
module nfcs_emit import nfcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  desc_t   desc,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res,
	output logic    out_last
);

	logic       valid_q;
	desc_t      desc_q;
	logic [2:0] idx_q;

	assign out_valid = valid_q;
	assign out_last  = idx_q == seq_last(desc_q.seq);
	assign out_res   = res_at(desc_q, idx_q);
	assign can_load  = !valid_q || (out_ready && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (out_last) valid_q <= 1'b0;
			else          idx_q   <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) desc_q <= desc;
	end

endmodule

@@ rtl/nor_flash_command_sequencer_unit.sv @@
// NOR flash command sequencer, top level: input register stage, command control
// and result emitter. Uses nfcs_pkg, nfcs_ctrl, nfcs_emit.
//
// Takes program, erase and identify commands and the flash's read responses, and
// returns the bus writes, bus read requests and a final done result each one calls
// for. Items with no result or one result stream at one per cycle while m_tready is
// high, and an item with no result never waits. An item with n results (up to eight:
// the erase sequence) holds the result stage, one bus access per output transaction,
// while a next item with results waits in the input register. Window registers
// are written through cfg_we/cfg_index/cfg_wdata (index 0 window_start, 1 window_end).
module nor_flash_command_sequencer_unit import nfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // addr[19:0], wdata[35:20], rdata[51:36], zero pad
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // bus_addr[19:0], bus_data[35:20], status[37:36], pad
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);

	logic    valid_s1;
	item_t   item_s1;
	logic    fire, load, can_load;
	desc_t   desc;
	result_t res;

	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func  <= s_tuser;
			item_s1.addr  <= s_tdata[19:0];
			item_s1.wdata <= s_tdata[35:20];
			item_s1.rdata <= s_tdata[51:36];
		end
	end

	nfcs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_valid (valid_s1),
		.item       (item_s1),
		.can_load   (can_load),
		.fire       (fire),
		.load       (load),
		.desc       (desc)
	);

	nfcs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.desc      (desc),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.out_last  (m_tlast)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {2'b00, res.status, res.bus_data, res.bus_addr};

endmodule
